[rtl/slru_pkg.sv]
// Shared types and constants for the segmented LRU tracker.
// No dependencies; imported by slru_state and segmented_lru_tracker.
`timescale 1ns / 1ps

package slru_pkg;

    localparam int ENTRY_W = 6;   // width of an entry index on the ports
    localparam int COUNT_W = 7;   // width of the protected count on the ports

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Result of one lookup, handed from the state block to the output register
    typedef struct packed {
        logic   found;
        logic   was_protected;
        logic   demoted_valid;
        entry_t demoted_entry;
        entry_t probation_coldest;
        count_t protected_count;
    } slru_result_t;

endpackage

[rtl/segmented_lru_tracker.sv]
// Top level of the segmented LRU tracker: input register, state block, result register.
// Depends on slru_pkg and slru_state.
`timescale 1ns / 1ps

// Segmented LRU tracker. Keeps the recency order of NUM_ENTRIES table entries
// split into a protected segment (at most PROTECT_CAP entries) and a
// probationary segment. Each input word names an entry and a hit flag; a miss
// or an index at or above NUM_ENTRIES changes nothing. A protected hit moves
// the entry to the protected warm end; a probation hit moves it to the
// protected cold end, first demoting the coldest protected entry to the
// probation warm end when the protected segment is full. Every input word
// yields exactly one result word, which also reports the next replacement
// victim (probation cold end, 0 if probation is empty) and the protected
// count. Throughput is one word per clock when the result side does not stall:
// the whole list update is combinational between the input register and the
// result register, over per-entry link flops. The only stalls come from the
// result side: while a result word waits on out_ready, the word in the input
// register holds and in_ready drops once that register is full. The state is
// ready right out of reset: protected holds entries 0 to PROTECT_CAP-1,
// probation the rest, both in ascending order from cold to warm.

module segmented_lru_tracker #(
    parameter int NUM_ENTRIES = 64,
    parameter int PROTECT_CAP = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  slru_pkg::entry_t    entry_index,
    input  logic                is_hit,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic                was_protected,
    output logic                demoted_valid,
    output slru_pkg::entry_t    demoted_entry,
    output slru_pkg::entry_t    probation_coldest,
    output slru_pkg::count_t    protected_count
);
    import slru_pkg::*;

    // input stage
    logic         s1_valid_reg;
    entry_t       s1_entry_reg;
    logic         s1_hit_reg;

    // result stage
    logic         out_valid_reg;
    slru_result_t out_reg;

    slru_result_t result;
    logic         advance;

    // the item in the input stage moves on when the result slot is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    slru_state #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .PROTECT_CAP (PROTECT_CAP)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd_en    (advance),
        .upd_entry (s1_entry_reg),
        .upd_hit   (s1_hit_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_entry_reg <= entry_index;
            s1_hit_reg   <= is_hit;
        end
        if (advance)
            out_reg <= result;
    end

    assign out_valid         = out_valid_reg;
    assign found             = out_reg.found;
    assign was_protected     = out_reg.was_protected;
    assign demoted_valid     = out_reg.demoted_valid;
    assign demoted_entry     = out_reg.demoted_entry;
    assign probation_coldest = out_reg.probation_coldest;
    assign protected_count   = out_reg.protected_count;

endmodule

[rtl/slru_state.sv]
// Recency state (per-entry segment flags, doubly linked lists, segment ends)
// and the combinational update for one lookup. Depends on slru_pkg.
`timescale 1ns / 1ps

module slru_state #(
    parameter int NUM_ENTRIES = 64,
    parameter int PROTECT_CAP = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      upd_en,
    input  slru_pkg::entry_t          upd_entry,
    input  logic                      upd_hit,
    output slru_pkg::slru_result_t    result
);
    import slru_pkg::*;

    localparam int LW      = $clog2(NUM_ENTRIES + 1);
    localparam int IW      = $clog2(NUM_ENTRIES);
    localparam int CAP_EFF = (PROTECT_CAP < NUM_ENTRIES) ? PROTECT_CAP : NUM_ENTRIES;

    typedef logic [LW-1:0] link_t;

    localparam link_t NIL           = LW'(NUM_ENTRIES);
    localparam link_t PROT_COLD_RST = LW'(0);
    localparam link_t PROT_WARM_RST = LW'(CAP_EFF - 1);
    localparam link_t PROB_COLD_RST = (CAP_EFF < NUM_ENTRIES) ? LW'(CAP_EFF) : NIL;
    localparam link_t PROB_WARM_RST = (CAP_EFF < NUM_ENTRIES) ? LW'(NUM_ENTRIES - 1) : NIL;
    localparam link_t SIZE_RST      = LW'(CAP_EFF);

    function automatic logic [IW-1:0] ix(input link_t l);
        return l[IW-1:0];
    endfunction

    logic  in_prot_reg   [NUM_ENTRIES];
    link_t next_link_reg [NUM_ENTRIES];
    link_t prev_link_reg [NUM_ENTRIES];
    link_t prot_cold_reg, prot_warm_reg, prob_cold_reg, prob_warm_reg, size_reg;

    logic  in_prot_next   [NUM_ENTRIES];
    link_t next_link_next [NUM_ENTRIES];
    link_t prev_link_next [NUM_ENTRIES];
    link_t prot_cold_next, prot_warm_next, prob_cold_next, prob_warm_next, size_next;

    logic          in_range, active, e_prot, demote;
    logic [IW-1:0] ei;
    link_t         e_link, p, n0, n, d, dn, head;

    always_comb
    begin
        in_range = ({{(32 - ENTRY_W){1'b0}}, upd_entry} < 32'(NUM_ENTRIES));
        active   = upd_en && upd_hit && in_range;
        ei       = IW'(upd_entry);
        e_link   = LW'(upd_entry);
        e_prot   = in_prot_reg[ei];
        p        = prev_link_reg[ei];
        n0       = next_link_reg[ei];
        d        = prot_cold_reg;
        dn       = (d != NIL) ? next_link_reg[ix(d)] : NIL;
        demote   = !e_prot && (32'(size_reg) >= 32'(PROTECT_CAP)) && (d != NIL);
        // a demoted entry lands right after e when e was the warm end of probation
        n        = (demote && n0 == NIL) ? d : n0;
        head     = demote ? dn : prot_cold_reg;

        in_prot_next   = in_prot_reg;
        next_link_next = next_link_reg;
        prev_link_next = prev_link_reg;
        prot_cold_next = prot_cold_reg;
        prot_warm_next = prot_warm_reg;
        prob_cold_next = prob_cold_reg;
        prob_warm_next = prob_warm_reg;
        size_next      = size_reg;

        if (active)
        begin
            if (e_prot)
            begin
                // move e to the protected warm end; nothing moves if it is already there
                if (n0 != NIL)
                begin
                    if (p != NIL)
                        next_link_next[ix(p)] = n0;
                    else
                        prot_cold_next = n0;
                    prev_link_next[ix(n0)]           = p;
                    next_link_next[ix(prot_warm_reg)] = e_link;
                    prev_link_next[ei]               = prot_warm_reg;
                    next_link_next[ei]               = NIL;
                    prot_warm_next                   = e_link;
                end
            end
            else
            begin
                if (demote)
                begin
                    // coldest protected entry goes to the warm end of probation
                    if (prob_warm_reg != NIL)
                        next_link_next[ix(prob_warm_reg)] = d;
                    next_link_next[ix(d)] = NIL;
                    prev_link_next[ix(d)] = prob_warm_reg;
                    in_prot_next[ix(d)]   = 1'b0;
                    prob_warm_next        = d;
                end
                // unlink e from probation
                if (p != NIL)
                    next_link_next[ix(p)] = n;
                else
                    prob_cold_next = n;
                if (n != NIL)
                    prev_link_next[ix(n)] = p;
                else
                    prob_warm_next = p;
                // push e at the cold end of the protected segment
                next_link_next[ei] = head;
                prev_link_next[ei] = NIL;
                if (head != NIL)
                    prev_link_next[ix(head)] = e_link;
                else
                    prot_warm_next = e_link;
                prot_cold_next   = e_link;
                in_prot_next[ei] = 1'b1;
                if (!demote)
                    size_next = size_reg + LW'(1);
            end
        end

        result.found             = active;
        result.was_protected     = active && e_prot;
        result.demoted_valid     = active && demote;
        result.demoted_entry     = (active && demote) ? ENTRY_W'(d) : '0;
        result.probation_coldest = (prob_cold_next != NIL) ? ENTRY_W'(prob_cold_next) : '0;
        result.protected_count   = COUNT_W'(size_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                in_prot_reg[i]   <= (i < CAP_EFF);
                next_link_reg[i] <= (i == CAP_EFF - 1 || i == NUM_ENTRIES - 1) ?
                                    NIL : LW'(i + 1);
                prev_link_reg[i] <= (i == 0 || i == CAP_EFF) ? NIL : LW'(i - 1);
            end
            prot_cold_reg <= PROT_COLD_RST;
            prot_warm_reg <= PROT_WARM_RST;
            prob_cold_reg <= PROB_COLD_RST;
            prob_warm_reg <= PROB_WARM_RST;
            size_reg      <= SIZE_RST;
        end
        else if (active)
        begin
            in_prot_reg   <= in_prot_next;
            next_link_reg <= next_link_next;
            prev_link_reg <= prev_link_next;
            prot_cold_reg <= prot_cold_next;
            prot_warm_reg <= prot_warm_next;
            prob_cold_reg <= prob_cold_next;
            prob_warm_reg <= prob_warm_next;
            size_reg      <= size_next;
        end
    end

    // protected segment never grows past its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(size_reg) <= 32'(CAP_EFF))
        else $error("protected size above capacity");

    // a hit entry is protected afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        active |=> in_prot_reg[$past(ei)])
        else $error("hit entry not protected");

    // protected hit lands at the warm end
    assert property (@(posedge clk) disable iff (!rst_n)
        (active && e_prot) |=> prot_warm_reg == $past(e_link))
        else $error("protected hit not at warm end");

    // probation hit lands at the protected cold end
    assert property (@(posedge clk) disable iff (!rst_n)
        (active && !e_prot) |=> prot_cold_reg == $past(e_link))
        else $error("probation hit not at protected cold end");

    // the probation cold end is never a protected entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (prob_cold_reg != NIL) |-> !in_prot_reg[ix(prob_cold_reg)])
        else $error("probation cold end marked protected");

endmodule

[bench/segmented_lru_tracker_test.sv]
// Self-checking bench for segmented_lru_tracker: directed and random lookup words.
// Depends on slru_pkg and the segmented_lru_tracker RTL.
`timescale 1ns / 1ps

module segmented_lru_tracker_test;

    import slru_pkg::*;

    localparam int NUM_ENTRIES = 64;
    localparam int PROTECT_CAP = 16;
    localparam int NIL         = NUM_ENTRIES;   // end-of-list marker in the link arrays
    localparam int RANDOM_WORDS = 600;

    typedef logic [6:0] link_t;

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   in_valid    = 1'b0;
    logic   in_ready;
    entry_t entry_index = '0;
    logic   is_hit      = 1'b0;
    logic   out_valid;
    logic   out_ready   = 1'b0;
    logic   found;
    logic   was_protected;
    logic   demoted_valid;
    entry_t demoted_entry;
    entry_t probation_coldest;
    count_t protected_count;

    segmented_lru_tracker #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .PROTECT_CAP (PROTECT_CAP)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .entry_index       (entry_index),
        .is_hit            (is_hit),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .found             (found),
        .was_protected     (was_protected),
        .demoted_valid     (demoted_valid),
        .demoted_entry     (demoted_entry),
        .probation_coldest (probation_coldest),
        .protected_count   (protected_count)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the recency lists. Each segment is a doubly linked
    // list running from its cold end to its warm end, NIL at the ends.
    // ------------------------------------------------------------------
    logic   seg_prot [NUM_ENTRIES];
    link_t  fwd_link [NUM_ENTRIES];
    link_t  back_link[NUM_ENTRIES];
    link_t  prot_cold, prot_warm, prob_cold, prob_warm;
    count_t prot_count;

    slru_result_t pending_results[$];   // predicted result words, oldest first

    int mismatch_count = 0;
    int hits_seen      = 0;
    int demotions_seen = 0;
    int misses_seen    = 0;
    int words_sent     = 0;

    // Remove an entry from whichever segment holds it
    function automatic void detach(int e);
        link_t p;
        link_t n;
        p = back_link[e];
        n = fwd_link[e];
        if (p != NIL) fwd_link[p] = n;
        else if (seg_prot[e]) prot_cold = n;
        else prob_cold = n;
        if (n != NIL) back_link[n] = p;
        else if (seg_prot[e]) prot_warm = p;
        else prob_warm = p;
        fwd_link[e]  = NIL;
        back_link[e] = NIL;
        if (seg_prot[e]) prot_count--;
    endfunction

    function automatic void append_warm(logic to_prot, int e);
        link_t w;
        w = to_prot ? prot_warm : prob_warm;
        back_link[e] = w;
        fwd_link[e]  = NIL;
        if (w != NIL) fwd_link[w] = link_t'(e);
        else if (to_prot) prot_cold = link_t'(e);
        else prob_cold = link_t'(e);
        if (to_prot) prot_warm = link_t'(e);
        else prob_warm = link_t'(e);
        seg_prot[e] = to_prot;
        if (to_prot) prot_count++;
    endfunction

    function automatic void insert_cold(logic to_prot, int e);
        link_t c;
        c = to_prot ? prot_cold : prob_cold;
        fwd_link[e]  = c;
        back_link[e] = NIL;
        if (c != NIL) back_link[c] = link_t'(e);
        else if (to_prot) prot_warm = link_t'(e);
        else prob_warm = link_t'(e);
        if (to_prot) prot_cold = link_t'(e);
        else prob_cold = link_t'(e);
        seg_prot[e] = to_prot;
        if (to_prot) prot_count++;
    endfunction

    // Post-reset order: first PROTECT_CAP entries protected, the rest on probation
    function automatic void restore_reset_order();
        prot_cold  = NIL;
        prot_warm  = NIL;
        prob_cold  = NIL;
        prob_warm  = NIL;
        prot_count = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            seg_prot[i]  = 1'b0;
            fwd_link[i]  = NIL;
            back_link[i] = NIL;
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
            append_warm(i < PROTECT_CAP, i);
    endfunction

    // Apply one lookup to the shadow lists and return the result word it yields
    function automatic slru_result_t predict_lookup(entry_t idx, logic hit);
        slru_result_t r;
        int           victim;
        r = '0;
        if (hit && idx < NUM_ENTRIES)
        begin
            r.found = 1'b1;
            if (seg_prot[idx])
            begin
                r.was_protected = 1'b1;
                detach(idx);
                append_warm(1'b1, idx);
            end
            else
            begin
                // full protected segment: its coldest entry drops to probation first
                if (prot_count >= PROTECT_CAP && prot_cold != NIL)
                begin
                    victim = prot_cold;
                    detach(victim);
                    append_warm(1'b0, victim);
                    r.demoted_valid = 1'b1;
                    r.demoted_entry = entry_t'(victim);
                end
                detach(idx);
                insert_cold(1'b1, idx);
            end
        end
        r.probation_coldest = (prob_cold != NIL) ? entry_t'(prob_cold) : '0;
        r.protected_count   = prot_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: words go out in bursts of random length separated by gaps
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic issue_lookup(input entry_t idx, input logic hit);
        int           gap;
        slru_result_t predicted;
        if (burst_left == 0)
        begin
            // now and then a long burst so some stretches run gap-free
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        entry_index <= idx;
        is_hit      <= hit;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // word accepted at this edge: update the shadow lists and log the expectation
        predicted       = predict_lookup(idx, hit);
        pending_results = {pending_results, predicted};
        words_sent++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready follows a pattern that is redrawn at random, switching
    // between always-ready, random, periodic and long stalls
    // ------------------------------------------------------------------
    int stall_mode  = 0;
    int mode_cycles = 0;
    int cycle_num   = 0;

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        slru_result_t want;
        cycle_num++;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with none expected (found=%0d entry=%0d)",
                         $time, found, demoted_entry);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("found", want.found, found);
                check_field("was_protected", want.was_protected, was_protected);
                check_field("demoted_valid", want.demoted_valid, demoted_valid);
                check_field("demoted_entry", want.demoted_entry, demoted_entry);
                check_field("probation_coldest", want.probation_coldest, probation_coldest);
                check_field("protected_count", want.protected_count, protected_count);
                if (!want.found) misses_seen++;
                else hits_seen++;
                if (want.demoted_valid) demotions_seen++;
            end
        end

        if (mode_cycles == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            mode_cycles = $urandom_range(20, 80);
        end
        mode_cycles--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= (cycle_num % 4 == 0);
            default: out_ready <= ($urandom_range(0, 15) == 0);   // long stalls
        endcase
    end

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Misses leave the lists alone, even when the index names a protected entry
    task automatic test_miss_words();
        issue_lookup(6'd0, 1'b0);
        issue_lookup(6'd63, 1'b0);
        issue_lookup(6'd5, 1'b0);
    endtask

    // Hits at both ends and the middle of the protected list, plus a repeat
    task automatic test_protected_hits();
        issue_lookup(entry_t'(prot_cold), 1'b1);
        issue_lookup(entry_t'(prot_warm), 1'b1);
        issue_lookup(6'd7, 1'b1);
        issue_lookup(6'd7, 1'b1);
    endtask

    // Probation hits on a full protected segment, each demoting; also protected hits and a miss
    task automatic test_probation_promotion();
        issue_lookup(entry_t'(prob_cold), 1'b1);
        issue_lookup(6'd63, 1'b1);
        issue_lookup(6'd40, 1'b1);
        issue_lookup(entry_t'(prot_cold), 1'b1);   // entry just placed at protected cold end
        issue_lookup(entry_t'(prob_warm), 1'b1);   // entry just demoted
        issue_lookup(entry_t'(prob_cold), 1'b1);
        issue_lookup(entry_t'(prob_cold), 1'b1);
        issue_lookup(6'd0, 1'b1);
        issue_lookup(6'd0, 1'b0);
    endtask

    // Mostly hits, steered toward list ends so entries keep cycling between segments
    task automatic test_random_traffic(input int count);
        int     sel;
        entry_t idx;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 25) idx = entry_t'(prob_cold);
            else if (sel < 40) idx = entry_t'(prot_cold);
            else if (sel < 50) idx = entry_t'(prob_warm);
            else idx = entry_t'($urandom_range(0, NUM_ENTRIES - 1));
            issue_lookup(idx, $urandom_range(0, 9) != 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int drain;
        restore_reset_order();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_miss_words();
        test_protected_hits();
        test_probation_promotion();
        test_random_traffic(RANDOM_WORDS);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        // keep clocking so a stray extra result word would be caught
        for (drain = 0; drain < 10; drain++) @(posedge clk);

        $display("Sent %0d lookup words: %0d hits, %0d misses checked.",
                 words_sent, hits_seen, misses_seen);
        $display("Saw %0d demotions from the protected segment.", demotions_seen);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d result words outstanding", pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/slru_pkg.sv
rtl/slru_state.sv
rtl/segmented_lru_tracker.sv
bench/segmented_lru_tracker_test.sv
